FILE: rtl/lcrs_pkg.sv
// shared types and constants of the line camera readout sequencer
`default_nettype none
package lcrs_pkg;

	localparam logic        ACT_TICK    = 1'b0;
	localparam logic        ACT_READ    = 1'b1;
	localparam logic [15:0] SCALE_RESET = 16'd255;

	typedef struct packed {
		logic        action;
		logic [15:0] adc_sample;
		logic [6:0]  pixel_index;
	} lcrs_req_t;

	typedef struct packed {
		logic        start_level;
		logic        clock_level;
		logic        frame_done;
		logic [15:0] pixel_value;
	} lcrs_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/lcrs_chan_if.sv
// valid/ready channel carrying one word of type T
`default_nettype none
interface lcrs_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/line_camera_readout_sequencer.sv
// top level: sensor start/clock sequencer with double-buffered pixel frame memory
//
// usage: each word on req is either a half-period tick (action 0) carrying the
// adc sample taken at that tick, or a read (action 1) of one pixel of the last
// complete frame. every req word gives exactly one rsp word, in order, holding
// the start and clock line levels after the word, the frame done flag and the
// pixel read (zero for ticks, for indexes beyond the line and before the
// first frame). cfg writes pixel_scale; it is always ready.
// rsp is valid in the cycle after req is accepted; a new word is taken
// every cycle as long as rsp is taken, so throughput is one word per cycle.
// the pixel memory holds two banks: ticks fill one while reads see the other,
// and the frame done tick swaps them, so publishing a line needs no copy.
// the memory read port is registered, like the other response fields.
// when rsp stalls, the result register holds and req.ready drops until the
// word is taken. reset puts the sequencer in the start-low phase with both
// lines low and marks no frame as published; no clearing pass is needed.
`default_nettype none
module line_camera_readout_sequencer
	import lcrs_pkg::*;
#(
	parameter int PIXELS = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	lcrs_chan_if.sink              req,
	lcrs_chan_if.source            rsp,
	lcrs_chan_if.sink              cfg
);

	localparam int AW         = $clog2(PIXELS);
	localparam int LAST_PHASE = 2 * PIXELS + 3;
	localparam int PW         = $clog2(LAST_PHASE + 1);
	localparam int DEPTH      = 2 ** (AW + 1);

	logic [15:0]   pixel_scale_q;
	logic [PW-1:0] phase_q;
	logic          start_q;
	logic          clock_q;
	logic          bank_q;
	logic          published_q;

	logic [15:0]   mem_q [DEPTH];
	logic [15:0]   rd_data_q;

	logic          valid_s1;
	logic          start_s1;
	logic          clock_s1;
	logic          done_s1;
	logic          pix_en_s1;

	logic          req_fire;
	logic          tick_fire;
	logic          read_fire;
	logic [PW-1:0] phase_d;
	logic          start_d;
	logic          clock_d;
	logic          done_d;
	logic          wr_en;
	logic [AW-1:0] wr_index;
	logic [31:0]   product;
	logic [AW+6:0] idx_wide;
	logic          idx_in_range;

	assign req.ready = !valid_s1 || rsp.ready;
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign tick_fire = req_fire && (req.data.action == ACT_TICK);
	assign read_fire = req_fire && (req.data.action == ACT_READ);

	assign product      = 32'(req.data.adc_sample) * 32'(pixel_scale_q);
	assign idx_wide     = {{AW{1'b0}}, req.data.pixel_index};
	assign idx_in_range = idx_wide < (AW + 7)'(PIXELS);
	// odd phases past the start hold the samples: pixel k sits at phase 2k+3
	assign wr_index     = AW'((phase_q >> 1) - PW'(1));

	// phase sequencer for one tick
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		clock_d = clock_q;
		done_d  = 1'b0;
		wr_en   = 1'b0;
		if (phase_q == PW'(0)) begin
			start_d = 1'b0;
			phase_d = PW'(1);
		end else if (phase_q == PW'(1)) begin
			start_d = 1'b1;
			phase_d = PW'(2);
		end else if (phase_q == PW'(LAST_PHASE - 1)) begin
			// extra clock pulse closing the line
			clock_d = 1'b1;
			phase_d = PW'(LAST_PHASE);
		end else if (phase_q >= PW'(LAST_PHASE)) begin
			clock_d = 1'b0;
			done_d  = 1'b1;
			phase_d = PW'(0);
		end else begin
			if (!phase_q[0]) begin
				clock_d = 1'b1;
			end else begin
				wr_en   = 1'b1;
				clock_d = 1'b0;
				if (phase_q == PW'(3)) begin
					start_d = 1'b0;
				end
			end
			phase_d = phase_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_scale_q <= SCALE_RESET;
		end else if (cfg.valid) begin
			pixel_scale_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			start_q     <= 1'b0;
			clock_q     <= 1'b0;
			bank_q      <= 1'b0;
			published_q <= 1'b0;
		end else if (tick_fire) begin
			phase_q <= phase_d;
			start_q <= start_d;
			clock_q <= clock_d;
			if (done_d) begin
				bank_q      <= !bank_q;
				published_q <= 1'b1;
			end
		end
	end

	// capture into the hidden bank, read from the published bank
	always_ff @(posedge clk) begin
		if (tick_fire && wr_en) begin
			mem_q[{!bank_q, wr_index}] <= product[31:16];
		end
		if (read_fire) begin
			rd_data_q <= mem_q[{bank_q, idx_wide[AW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			if (req.data.action == ACT_TICK) begin
				start_s1  <= start_d;
				clock_s1  <= clock_d;
				done_s1   <= done_d;
				pix_en_s1 <= 1'b0;
			end else begin
				start_s1  <= start_q;
				clock_s1  <= clock_q;
				done_s1   <= 1'b0;
				pix_en_s1 <= idx_in_range && published_q;
			end
		end
	end

	assign rsp.valid            = valid_s1;
	assign rsp.data.start_level = start_s1;
	assign rsp.data.clock_level = clock_s1;
	assign rsp.data.frame_done  = done_s1;
	assign rsp.data.pixel_value = pix_en_s1 ? rd_data_q : 16'd0;

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PW'(LAST_PHASE))
		else $error("phase counter past last phase");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_fire |=> $stable(phase_q))
		else $error("phase moved without a tick");

	a_done_lines_low: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.frame_done |-> !rsp.data.clock_level && !rsp.data.start_level)
		else $error("frame done with a sensor line high");

	a_no_pixel_before_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.pixel_value != 16'd0) |-> published_q)
		else $error("pixel returned before any frame published");

	a_write_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire && wr_en |-> (32'(wr_index) < PIXELS))
		else $error("capture write beyond the line");
`endif

endmodule
`default_nettype wire
